/* rtl/assert_macros.svh */
// Assertion macros shared by the encoder RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset
`define LZ_ASSERT(lbl, clk_i, rstn_i, prop) \
	lbl: assert property (@(posedge clk_i) disable iff (!rstn_i) prop) \
		else $error("lz78e assertion failed");

// Condition that must never be seen outside reset
`define LZ_ASSERT_NEVER(lbl, clk_i, rstn_i, expr) \
	`LZ_ASSERT(lbl, clk_i, rstn_i, !(expr))

`endif

/* rtl/lz78e_pkg.sv */
// Shared types, constants and control structs of the LZ78 dictionary encoder
`default_nettype none

package lz78e_pkg;

	localparam int unsigned PREFIX_W      = 12;
	localparam int unsigned CW_W          = 4;
	localparam int unsigned BYTE_W        = 8;
	localparam int unsigned MCB_W         = 4;
	localparam int unsigned CODE_BITS_DEF = 12;
	localparam logic [MCB_W-1:0] MCB_RESET = 4'd12;

	typedef struct packed {
		logic [BYTE_W-1:0] data_byte;
		logic              end_of_stream;
	} in_item_t;

	typedef struct packed {
		logic [PREFIX_W-1:0] prefix_code;
		logic [CW_W-1:0]     code_width;
		logic [BYTE_W-1:0]   literal_byte;
		logic                final_pair;
	} out_item_t;

	typedef logic [MCB_W-1:0] cfg_item_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SEARCH,
		ST_EMIT
	} ctl_state_t;

	// Commands from controller to datapath
	typedef struct packed {
		logic start;
		logic search;
		logic take_found;
		logic emit;
	} dp_cmd_t;

	// Status from datapath to controller
	typedef struct packed {
		logic hit;
		logic done;
		logic eos;
		logic slot_free;
	} dp_status_t;

endpackage

`default_nettype wire

/* rtl/lz78e_chan_if.sv */
// Valid/ready channel interface carrying one payload per transfer
`default_nettype none

interface lz78e_chan_if #(parameter type payload_t = logic);
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

/* rtl/lz78e_ram.sv */
// Generic single-write, single-read RAM with registered read data
`default_nettype none

module lz78e_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

/* rtl/lz78e_ctrl.sv */
// Controller state machine: accept, dictionary search, pair emission
`default_nettype none
`include "assert_macros.svh"

module lz78e_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  lz78e_pkg::dp_status_t status,
	output lz78e_pkg::dp_cmd_t    cmd
);
	import lz78e_pkg::*;

	ctl_state_t state_q;
	ctl_state_t state_d;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_d = ST_SEARCH;
				end
			end
			ST_SEARCH: begin
				if (status.hit) begin
					state_d = status.eos ? ST_EMIT : ST_IDLE;
				end else if (status.done) begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (status.slot_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Outputs
	always_comb begin
		in_ready       = 1'b0;
		cmd            = '0;
		case (state_q)
			ST_IDLE: begin
				in_ready  = 1'b1;
				cmd.start = in_valid;
			end
			ST_SEARCH: begin
				cmd.search     = 1'b1;
				cmd.take_found = status.hit & ~status.eos;
			end
			ST_EMIT: begin
				cmd.emit = status.slot_free;
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

	// An extended prefix returns straight to accepting the next byte
	`LZ_ASSERT(a_extend_to_idle, clk, arst_n,
		(state_q == ST_SEARCH && status.hit && !status.eos) |=> (state_q == ST_IDLE))

endmodule

`default_nettype wire

/* rtl/lz78e_datapath.sv */
// Datapath: dictionary RAM, search pipeline, counters and output register
`default_nettype none
`include "assert_macros.svh"

module lz78e_datapath #(
	parameter int unsigned CODE_BITS = lz78e_pkg::CODE_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  lz78e_pkg::dp_cmd_t    cmd,
	output lz78e_pkg::dp_status_t status,
	input  lz78e_pkg::in_item_t   item,
	input  logic                  cfg_valid,
	input  lz78e_pkg::cfg_item_t  cfg_data,
	output logic                  cfg_ready,
	output logic                  out_valid,
	input  logic                  out_ready,
	output lz78e_pkg::out_item_t  out_item
);
	import lz78e_pkg::*;

	localparam int unsigned DEPTH   = 2 ** CODE_BITS;
	localparam int unsigned CNT_W   = CODE_BITS + 1;
	localparam int unsigned ENTRY_W = PREFIX_W + BYTE_W;

	logic [MCB_W-1:0]     mcb_q;
	logic [CNT_W-1:0]     count_q;
	logic [PREFIX_W-1:0]  prefix_q;
	logic [BYTE_W-1:0]    byte_q;
	logic                 eos_q;
	logic [CNT_W-1:0]     idx_q;
	logic                 rd_vld_s1;
	logic [CODE_BITS-1:0] rd_idx_s1;
	logic                 out_valid_q;
	out_item_t            out_q;

	logic [4:0]           bits;
	logic [CNT_W-1:0]     limit;
	logic                 issue;
	logic [ENTRY_W-1:0]   rd_entry;
	logic                 hit;
	logic [CNT_W-1:0]     found_code;

	// Bit length of n, which equals ceil(log2(n + 1)), kept to the field width
	function automatic logic [CW_W-1:0] width_of(input logic [CNT_W-1:0] n);
		logic [CW_W-1:0] w;
		w = '0;
		for (int i = 0; i < CNT_W; i++) begin
			if (n[i]) begin
				w = CW_W'(i + 1);
			end
		end
		return w;
	endfunction

	// Dictionary size limit, saturated at the RAM depth
	always_comb begin
		bits  = ({1'b0, mcb_q} > 5'(CODE_BITS)) ? 5'(CODE_BITS) : {1'b0, mcb_q};
		limit = CNT_W'(1) << bits;
	end

	assign issue      = cmd.search && (idx_q < count_q);
	assign hit        = rd_vld_s1 && (rd_entry == {prefix_q, byte_q});
	assign found_code = CNT_W'(rd_idx_s1) + CNT_W'(1);

	assign cfg_ready = 1'b1;

	// Configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mcb_q <= MCB_RESET;
		end else if (cfg_valid) begin
			mcb_q <= cfg_data;
		end
	end

	// Entry count: clear a full dictionary on accept, advance on append
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.start && (count_q >= limit)) begin
			count_q <= '0;
		end else if (cmd.emit) begin
			count_q <= count_q + CNT_W'(1);
		end
	end

	// Current prefix: extend on a hit, clear after a pair goes out
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prefix_q <= '0;
		end else if (cmd.take_found) begin
			prefix_q <= PREFIX_W'(found_code);
		end else if (cmd.emit) begin
			prefix_q <= '0;
		end
	end

	// Hold the accepted byte
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			byte_q <= item.data_byte;
			eos_q  <= item.end_of_stream;
		end
	end

	// Search address counter and read-valid stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q     <= '0;
			rd_vld_s1 <= 1'b0;
		end else begin
			rd_vld_s1 <= issue;
			if (cmd.start) begin
				idx_q <= '0;
			end else if (issue) begin
				idx_q <= idx_q + CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		rd_idx_s1 <= idx_q[CODE_BITS-1:0];
	end

	// Dictionary: entry k stored at address k-1
	lz78e_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(DEPTH)
	) u_dict (
		.clk   (clk),
		.we    (cmd.emit),
		.waddr (count_q[CODE_BITS-1:0]),
		.wdata ({prefix_q, byte_q}),
		.raddr (idx_q[CODE_BITS-1:0]),
		.rdata (rd_entry)
	);

	// Output register: load on emit, drop on transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_q.prefix_code  <= prefix_q;
			out_q.code_width   <= width_of(count_q);
			out_q.literal_byte <= byte_q;
			out_q.final_pair   <= eos_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_q;

	always_comb begin
		status.hit       = hit;
		status.done      = (idx_q >= count_q) && !rd_vld_s1;
		status.eos       = eos_q;
		status.slot_free = !out_valid_q || out_ready;
	end

	// Reads in flight address only filled entries
	`LZ_ASSERT(a_rd_in_range, clk, arst_n, rd_vld_s1 |-> ({1'b0, rd_idx_s1} < count_q))
	// Count never runs past the dictionary depth
	`LZ_ASSERT_NEVER(a_count_bound, clk, arst_n, count_q > CNT_W'(DEPTH))
	// An emitted pair is presented in the next cycle
	`LZ_ASSERT(a_emit_loads, clk, arst_n, cmd.emit |=> out_valid_q)

endmodule

`default_nettype wire

/* rtl/lz78_dictionary_encoder.sv */
// Top level of the LZ78 dictionary encoder
`default_nettype none

// LZ78 dictionary encoder. Bytes arrive on items, one per transfer, with
// end_of_stream marking the last; (prefix code, code width, byte) pairs leave
// on pairs, at most one per byte. An item is accepted, then the dictionary
// entries are searched through the registered read pipeline, then the pair
// is appended and emitted once the output register is free. The search is
// linear through the dictionary RAM, which reads one entry per cycle. An
// item that extends the prefix stops at the first matching entry and emits
// nothing. A finished pair waits in an output register while the next byte
// is accepted. The dictionary RAM is not cleared after reset; only entries
// already written are read. The user must write max_code_bits (cfg) only
// while the block is idle; the block itself does not enforce this. It takes
// effect at the next accepted byte.
module lz78_dictionary_encoder #(
	parameter int unsigned CODE_BITS = lz78e_pkg::CODE_BITS_DEF
) (
	input logic         clk,
	input logic         arst_n,
	lz78e_chan_if.sink   items,
	lz78e_chan_if.sink   cfg,
	lz78e_chan_if.source pairs
);
	import lz78e_pkg::*;

	dp_cmd_t    cmd;
	dp_status_t status;

	lz78e_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (items.valid),
		.in_ready (items.ready),
		.status   (status),
		.cmd      (cmd)
	);

	lz78e_datapath #(
		.CODE_BITS(CODE_BITS)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.status    (status),
		.item      (items.payload),
		.cfg_valid (cfg.valid),
		.cfg_data  (cfg.payload),
		.cfg_ready (cfg.ready),
		.out_valid (pairs.valid),
		.out_ready (pairs.ready),
		.out_item  (pairs.payload)
	);

endmodule

`default_nettype wire
